// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and character helpers for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_W   = 32;
  localparam int RES_MAX = 4;
  localparam int CNT_W   = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [4:0] {
    TOK_IF = 5'd0, TOK_ELSE, TOK_WHILE, TOK_RETURN, TOK_IDENT, TOK_NUMBER,
    TOK_STRING, TOK_ASSIGN, TOK_EQUAL, TOK_BANG, TOK_NOT_EQUAL, TOK_LESS,
    TOK_LESS_EQUAL, TOK_GREATER, TOK_GREATER_EQUAL, TOK_SLASH, TOK_PLUS,
    TOK_MINUS, TOK_STAR, TOK_SEMI, TOK_LPAREN, TOK_RPAREN, TOK_LBRACE,
    TOK_RBRACE, TOK_ERROR, TOK_EOF
  } tok_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_UNEXPECTED = 2'd1, ERR_UNTERMINATED = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_ESCAPE, M_OP, M_LINECOM,
    M_BLOCK, M_BLOCKSTAR
  } mode_e;

  typedef struct packed {
    logic             out_kind;
    logic [7:0]       lexeme_byte;
    tok_e             token_type;
    err_e             error_code;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] len;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]          n;
    res_t [RES_MAX-1:0]        res;
  } bundle_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "/";
  endfunction

  function automatic tok_e single_op_type(logic [7:0] op);
    tok_e t;
    unique case (op)
      "=":     t = TOK_ASSIGN;
      "!":     t = TOK_BANG;
      "<":     t = TOK_LESS;
      ">":     t = TOK_GREATER;
      default: t = TOK_SLASH;
    endcase
    return t;
  endfunction

  function automatic tok_e double_op_type(logic [7:0] op);
    tok_e t;
    unique case (op)
      "=":     t = TOK_EQUAL;
      "!":     t = TOK_NOT_EQUAL;
      "<":     t = TOK_LESS_EQUAL;
      default: t = TOK_GREATER_EQUAL;
    endcase
    return t;
  endfunction

  function automatic tok_e punct_type(logic [7:0] c);
    tok_e t;
    unique case (c)
      "+":     t = TOK_PLUS;
      "-":     t = TOK_MINUS;
      "*":     t = TOK_STAR;
      ";":     t = TOK_SEMI;
      "(":     t = TOK_LPAREN;
      ")":     t = TOK_RPAREN;
      "{":     t = TOK_LBRACE;
      "}":     t = TOK_RBRACE;
      default: t = TOK_ERROR;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Scanner: takes one item a cycle while take_i is set; builds its results.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
  parameter int LINE_BITS         = 16,
  parameter int COLUMN_BITS       = 16,
  parameter int LENGTH_BITS       = 16,
  parameter int KEYWORD_MAX_CHARS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic       kind_i,
  input  logic [7:0] char_code_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  localparam int KIW = $clog2(KEYWORD_MAX_CHARS);

  typedef struct packed {
    mode_e                                mode;
    logic [7:0]                           pend;
    logic [LINE_BITS-1:0]                 line;
    logic [COLUMN_BITS-1:0]               col;
    logic [LINE_BITS-1:0]                 sl;
    logic [COLUMN_BITS-1:0]               sc;
    logic [LENGTH_BITS-1:0]               tl;
    logic                                 dot;
    logic [KEYWORD_MAX_CHARS-1:0][7:0]    kp;
    logic [CNT_W-1:0]                     n;
    res_t [RES_MAX-1:0]                   res;
  } wk_t;

  function automatic wk_t put(wk_t w, logic ok, logic [7:0] b, tok_e ty, err_e er,
                              logic [POS_W-1:0] ln, logic [POS_W-1:0] cl,
                              logic [POS_W-1:0] ls);
    res_t r;
    r.out_kind    = ok;
    r.lexeme_byte = b;
    r.token_type  = ty;
    r.error_code  = er;
    r.line        = ln;
    r.col         = cl;
    r.len         = ls;
    w.res[w.n[1:0]] = r;
    w.n = w.n + CNT_W'(1);
    return w;
  endfunction

  function automatic wk_t emit_byte(wk_t w, logic [7:0] b);
    if (w.tl < LENGTH_BITS'(KEYWORD_MAX_CHARS)) w.kp[w.tl[KIW-1:0]] = b;
    if (w.tl != '1) w.tl = w.tl + LENGTH_BITS'(1);
    return put(w, 1'b0, b, TOK_IF, ERR_NONE, '0, '0, '0);
  endfunction

  function automatic wk_t emit_desc(wk_t w, tok_e ty, err_e er);
    return put(w, 1'b1, 8'd0, ty, er, POS_W'(w.sl), POS_W'(w.sc), POS_W'(w.tl));
  endfunction

  function automatic wk_t finish_ident(wk_t w);
    tok_e ty;
    ty = TOK_IDENT;
    if (w.tl == LENGTH_BITS'(2) && w.kp[0] == "i" && w.kp[1] == "f") ty = TOK_IF;
    if (w.tl == LENGTH_BITS'(4) && w.kp[0] == "e" && w.kp[1] == "l" &&
        w.kp[2] == "s" && w.kp[3] == "e") ty = TOK_ELSE;
    if (w.tl == LENGTH_BITS'(5) && w.kp[0] == "w" && w.kp[1] == "h" &&
        w.kp[2] == "i" && w.kp[3] == "l" && w.kp[4] == "e") ty = TOK_WHILE;
    if (w.tl == LENGTH_BITS'(6) && w.kp[0] == "r" && w.kp[1] == "e" &&
        w.kp[2] == "t" && w.kp[3] == "u" && w.kp[4] == "r" &&
        w.kp[5] == "n") ty = TOK_RETURN;
    return emit_desc(w, ty, ERR_NONE);
  endfunction

  function automatic wk_t dispatch(wk_t w, logic [7:0] c);
    tok_e ty;
    w.mode = M_IDLE;
    if (!is_space(c)) begin
      w.sl = w.line;
      w.sc = w.col;
      w.tl = '0;
      if (c == CH_QUOTE) begin
        w.mode = M_STRING;
      end else if (is_alpha(c) || c == CH_UNDER) begin
        w.mode = M_IDENT;
        w = emit_byte(w, c);
      end else if (is_digit(c)) begin
        w.mode = M_NUMBER;
        w.dot  = 1'b0;
        w = emit_byte(w, c);
      end else if (is_op(c)) begin
        w.mode = M_OP;
        w.pend = c;
      end else begin
        ty = punct_type(c);
        w = emit_byte(w, c);
        w = emit_desc(w, ty, (ty == TOK_ERROR) ? ERR_UNEXPECTED : ERR_NONE);
      end
    end
    return w;
  endfunction

  wk_t st_q, st_d, rst_w;

  always_comb begin
    rst_w      = '0;
    rst_w.mode = M_IDLE;
    rst_w.line = LINE_BITS'(1);
    rst_w.sl   = LINE_BITS'(1);
  end

  always_comb begin
    wk_t w;
    w     = st_q;
    w.n   = '0;
    w.res = '0;
    if (kind_i) begin
      if (w.col != '1) w.col = w.col + COLUMN_BITS'(1);
      case (w.mode)
        M_IDENT:            w = finish_ident(w);
        M_NUMBER:           w = emit_desc(w, TOK_NUMBER, ERR_NONE);
        M_STRING, M_ESCAPE: w = emit_desc(w, TOK_ERROR, ERR_UNTERMINATED);
        M_OP: begin
          w = emit_byte(w, w.pend);
          w = emit_desc(w, single_op_type(w.pend), ERR_NONE);
        end
        default: ;
      endcase
      w = put(w, 1'b1, 8'd0, TOK_EOF, ERR_NONE, POS_W'(w.line), POS_W'(w.col), '0);
      w.mode = rst_w.mode;
      w.pend = rst_w.pend;
      w.line = rst_w.line;
      w.col  = rst_w.col;
      w.sl   = rst_w.sl;
      w.sc   = rst_w.sc;
      w.tl   = rst_w.tl;
      w.dot  = rst_w.dot;
    end else begin
      if (char_code_i == CH_NL) begin
        if (w.line != '1) w.line = w.line + LINE_BITS'(1);
        w.col = '0;
      end else if (w.col != '1) begin
        w.col = w.col + COLUMN_BITS'(1);
      end
      case (w.mode)
        M_IDENT: begin
          if (is_alpha(char_code_i) || is_digit(char_code_i) || char_code_i == CH_UNDER) begin
            w = emit_byte(w, char_code_i);
          end else begin
            w = finish_ident(w);
            w = dispatch(w, char_code_i);
          end
        end
        M_NUMBER: begin
          if (is_digit(char_code_i) || (char_code_i == CH_DOT && !w.dot)) begin
            if (char_code_i == CH_DOT) w.dot = 1'b1;
            w = emit_byte(w, char_code_i);
          end else begin
            w = emit_desc(w, TOK_NUMBER, ERR_NONE);
            w = dispatch(w, char_code_i);
          end
        end
        M_STRING: begin
          if (char_code_i == CH_QUOTE) begin
            w = emit_desc(w, TOK_STRING, ERR_NONE);
            w.mode = M_IDLE;
          end else if (char_code_i == CH_NL) begin
            w = emit_desc(w, TOK_ERROR, ERR_UNTERMINATED);
            w.mode = M_IDLE;
          end else if (char_code_i == CH_BSL) begin
            w.mode = M_ESCAPE;
          end else begin
            w = emit_byte(w, char_code_i);
          end
        end
        M_ESCAPE: begin
          if (char_code_i == "n") w = emit_byte(w, CH_NL);
          else if (char_code_i == "t") w = emit_byte(w, CH_TAB);
          else w = emit_byte(w, char_code_i);
          w.mode = M_STRING;
        end
        M_OP: begin
          if (w.pend == CH_SLASH) begin
            if (char_code_i == CH_SLASH) begin
              w.mode = M_LINECOM;
            end else if (char_code_i == CH_STAR) begin
              w.mode = M_BLOCK;
            end else begin
              w = emit_byte(w, CH_SLASH);
              w = emit_desc(w, TOK_SLASH, ERR_NONE);
              w = dispatch(w, char_code_i);
            end
          end else if (char_code_i == CH_EQ) begin
            w = emit_byte(w, w.pend);
            w = emit_byte(w, CH_EQ);
            w = emit_desc(w, double_op_type(w.pend), ERR_NONE);
            w.mode = M_IDLE;
          end else begin
            w = emit_byte(w, w.pend);
            w = emit_desc(w, single_op_type(w.pend), ERR_NONE);
            w = dispatch(w, char_code_i);
          end
        end
        M_LINECOM: if (char_code_i == CH_NL) w.mode = M_IDLE;
        M_BLOCK:   if (char_code_i == CH_STAR) w.mode = M_BLOCKSTAR;
        M_BLOCKSTAR: begin
          if (char_code_i == CH_SLASH) w.mode = M_IDLE;
          else if (char_code_i != CH_STAR) w.mode = M_BLOCK;
        end
        default: w = dispatch(w, char_code_i);
      endcase
    end
    st_d = w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rst_w;
    end else if (take_i) begin
      st_q <= st_d;
    end
  end

  assign bundle_o.n   = st_d.n;
  assign bundle_o.res = st_d.res;
  assign push_o       = take_i && (st_d.n != '0);

endmodule

// ===== rtl/stt_fifo.sv =====
// ----------------------------------------------------------------------------
// stt_fifo
// Short bundle queue between the scanner and the result sequencer.
// ----------------------------------------------------------------------------
module stt_fifo import stt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output bundle_t data_o
);

  bundle_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_PTR_W:0]     cnt_q;

  assign full_o  = cnt_q == (Q_PTR_W+1)'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + Q_PTR_W'(1);
      if (pop_i)  rd_q <= rd_q + Q_PTR_W'(1);
      cnt_q <= cnt_q + (Q_PTR_W+1)'(push_i) - (Q_PTR_W+1)'(pop_i);
    end
  end

endmodule

// ===== rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Result sequencer: unpacks bundles into single results in an output register.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  bundle_t head_i,
  output logic    head_pop_o,
  input  logic    pop_i,
  output logic    valid_o,
  output res_t    res_o,
  output logic    last_o
);

  logic [1:0] idx_q;
  logic       vld_q, last_q;
  res_t       res_q;
  logic       load, is_last;

  assign load       = head_valid_i && (!vld_q || pop_i);
  assign is_last    = {1'b0, idx_q} == (head_i.n - CNT_W'(1));
  assign head_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.res[idx_q];
      last_q <= is_last;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;
  assign last_o  = last_q;

endmodule

// ===== rtl/source_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexer for a small C-like language, byte in, lexeme bytes and
// token descriptors out.
// ----------------------------------------------------------------------------
// The scanner takes one item per cycle whenever its four-entry bundle queue
// has room; an item yields zero to four results, which leave one per cycle
// from the output register while pop is held. Sustained throughput is set by
// the single result port: items or results, whichever are more numerous.
// Results pass through the bundle queue, then the output register.
module source_text_tokenizer_unit import stt_pkg::*; #(
  parameter int LINE_BITS         = 16,
  parameter int COLUMN_BITS       = 16,
  parameter int LENGTH_BITS       = 16,
  parameter int KEYWORD_MAX_CHARS = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   kind_i,
  input  logic [7:0]             char_code_i,
  output logic                   empty,
  input  logic                   pop,
  output logic                   out_kind_o,
  output logic [7:0]             lexeme_byte_o,
  output logic [4:0]             token_type_o,
  output logic [1:0]             error_code_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [COLUMN_BITS-1:0] start_column_o,
  output logic [LENGTH_BITS-1:0] lexeme_length_o,
  output logic                   last_o
);

  logic    take, q_push, q_full, q_valid, q_pop, out_valid, out_pop;
  bundle_t q_in, q_head;
  res_t    res;

  assign take    = push && !q_full;
  assign full    = q_full;
  assign out_pop = pop && out_valid;

  stt_front #(
    .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS),
    .LENGTH_BITS(LENGTH_BITS), .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)
  ) u_front (
    .clk_i, .rst_ni, .take_i(take), .kind_i, .char_code_i,
    .push_o(q_push), .bundle_o(q_in)
  );

  stt_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_head)
  );

  stt_back u_back (
    .clk_i, .rst_ni, .head_valid_i(q_valid), .head_i(q_head), .head_pop_o(q_pop),
    .pop_i(out_pop), .valid_o(out_valid), .res_o(res), .last_o
  );

  assign empty           = !out_valid;
  assign out_kind_o      = res.out_kind;
  assign lexeme_byte_o   = res.lexeme_byte;
  assign token_type_o    = res.token_type;
  assign error_code_o    = res.error_code;
  assign start_line_o    = res.line[LINE_BITS-1:0];
  assign start_column_o  = res.col[COLUMN_BITS-1:0];
  assign lexeme_length_o = res.len[LENGTH_BITS-1:0];

  a_byte_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_kind_o) |-> (token_type_o == TOK_IF && lexeme_length_o == '0))
    else $error("lexeme byte result carries descriptor fields");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_kind_o && token_type_o == TOK_EOF) |-> last_o)
    else $error("end token not marked last");

  a_err_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_code_o != ERR_NONE) |-> token_type_o == TOK_ERROR)
    else $error("error code on non-error token");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("bundle pushed into full queue");

endmodule

// ===== tb/sv/tb_source_text_tokenizer_checker.sv =====
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer_checker
// Watches both sides of the tokenizer, predicts the lexeme bytes and token
// descriptors of every accepted item and compares each popped result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_checker import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic        kind_i,
  input  logic [7:0]  char_code_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        out_kind_o,
  input  logic [7:0]  lexeme_byte_o,
  input  logic [4:0]  token_type_o,
  input  logic [1:0]  error_code_o,
  input  logic [15:0] start_line_o,
  input  logic [15:0] start_column_o,
  input  logic [15:0] lexeme_length_o,
  input  logic        last_o,
  output int          fails_o,
  output int          pending_o
);

  localparam int unsigned SAT = 16'hFFFF;

  typedef struct {
    logic        is_desc;
    logic [7:0]  lex;
    tok_e        tok;
    err_e        err;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } token_res_t;

  token_res_t  expected_tokens[$];
  mode_e       mode;
  logic [7:0]  held_op;
  int unsigned cur_line, cur_col, tok_line, tok_col, tok_len;
  logic        dot_seen;
  logic [7:0]  word[6];
  string       keywords[4] = '{"if", "else", "while", "return"};

  assign pending_o = expected_tokens.size();

  function automatic bit letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic tok_e lone_op(logic [7:0] c);
    case (c)
      8'h3D:   return TOK_ASSIGN;
      8'h21:   return TOK_BANG;
      8'h3C:   return TOK_LESS;
      8'h3E:   return TOK_GREATER;
      default: return TOK_SLASH;
    endcase
  endfunction

  function automatic void add_res(logic d, logic [7:0] b, tok_e t, err_e e,
                                  int unsigned ln, int unsigned cl, int unsigned lg);
    token_res_t r;
    r.is_desc = d; r.lex = b; r.tok = t; r.err = e;
    r.line = ln[15:0]; r.col = cl[15:0]; r.len = lg[15:0]; r.last = 1'b0;
    expected_tokens.push_back(r);
  endfunction

  function automatic void lex_byte(logic [7:0] b);
    if (tok_len < 6) word[tok_len] = b;
    if (tok_len < SAT) tok_len++;
    add_res(1'b0, b, TOK_IF, ERR_NONE, 0, 0, 0);
  endfunction

  function automatic void token_desc(tok_e t, err_e e);
    add_res(1'b1, 8'h00, t, e, tok_line, tok_col, tok_len);
  endfunction

  function automatic void word_desc();
    tok_e t;
    bit   same;
    t = TOK_IDENT;
    for (int k = 0; k < 4; k++) begin
      if (tok_len == keywords[k].len()) begin
        same = 1;
        for (int i = 0; i < keywords[k].len(); i++)
          if (word[i] != keywords[k][i]) same = 0;
        if (same) t = tok_e'(k);
      end
    end
    token_desc(t, ERR_NONE);
  endfunction

  function automatic void start_token(logic [7:0] c);
    tok_e t;
    mode = M_IDLE;
    if (blank(c)) return;
    tok_line = cur_line;
    tok_col  = cur_col;
    tok_len  = 0;
    if (c == CH_QUOTE) begin
      mode = M_STRING;
    end else if (letter(c)) begin
      mode = M_IDENT;
      lex_byte(c);
    end else if (digit(c)) begin
      mode = M_NUMBER;
      dot_seen = 0;
      lex_byte(c);
    end else if (c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E || c == CH_SLASH) begin
      mode = M_OP;
      held_op = c;
    end else begin
      case (c)
        8'h2B:   t = TOK_PLUS;
        8'h2D:   t = TOK_MINUS;
        8'h2A:   t = TOK_STAR;
        8'h3B:   t = TOK_SEMI;
        8'h28:   t = TOK_LPAREN;
        8'h29:   t = TOK_RPAREN;
        8'h7B:   t = TOK_LBRACE;
        8'h7D:   t = TOK_RBRACE;
        default: t = TOK_ERROR;
      endcase
      lex_byte(c);
      token_desc(t, t == TOK_ERROR ? ERR_UNEXPECTED : ERR_NONE);
    end
  endfunction

  function automatic void clear_scan();
    mode = M_IDLE; held_op = 8'h00;
    cur_line = 1; cur_col = 0; tok_line = 1; tok_col = 0; tok_len = 0;
    dot_seen = 0;
  endfunction

  function automatic void tokenize_item(logic k, logic [7:0] c);
    int first;
    first = expected_tokens.size();
    if (k) begin
      if (cur_col < SAT) cur_col++;
      case (mode)
        M_IDENT:           word_desc();
        M_NUMBER:          token_desc(TOK_NUMBER, ERR_NONE);
        M_STRING, M_ESCAPE: token_desc(TOK_ERROR, ERR_UNTERMINATED);
        M_OP: begin
          lex_byte(held_op);
          token_desc(lone_op(held_op), ERR_NONE);
        end
        default: ;
      endcase
      add_res(1'b1, 8'h00, TOK_EOF, ERR_NONE, cur_line, cur_col, 0);
      clear_scan();
    end else begin
      if (c == CH_NL) begin
        if (cur_line < SAT) cur_line++;
        cur_col = 0;
      end else if (cur_col < SAT) begin
        cur_col++;
      end
      case (mode)
        M_IDENT:
          if (letter(c) || digit(c)) lex_byte(c);
          else begin word_desc(); start_token(c); end
        M_NUMBER:
          if (digit(c) || (c == CH_DOT && !dot_seen)) begin
            if (c == CH_DOT) dot_seen = 1;
            lex_byte(c);
          end else begin
            token_desc(TOK_NUMBER, ERR_NONE);
            start_token(c);
          end
        M_STRING:
          if (c == CH_QUOTE) begin
            token_desc(TOK_STRING, ERR_NONE); mode = M_IDLE;
          end else if (c == CH_NL) begin
            token_desc(TOK_ERROR, ERR_UNTERMINATED); mode = M_IDLE;
          end else if (c == CH_BSL) begin
            mode = M_ESCAPE;
          end else begin
            lex_byte(c);
          end
        M_ESCAPE: begin
          if (c == 8'h6E) lex_byte(CH_NL);
          else if (c == 8'h74) lex_byte(CH_TAB);
          else lex_byte(c);
          mode = M_STRING;
        end
        M_OP:
          if (held_op == CH_SLASH) begin
            if (c == CH_SLASH) mode = M_LINECOM;
            else if (c == CH_STAR) mode = M_BLOCK;
            else begin
              lex_byte(CH_SLASH);
              token_desc(TOK_SLASH, ERR_NONE);
              start_token(c);
            end
          end else if (c == CH_EQ) begin
            lex_byte(held_op);
            lex_byte(CH_EQ);
            token_desc(tok_e'(lone_op(held_op) + 1), ERR_NONE);
            mode = M_IDLE;
          end else begin
            lex_byte(held_op);
            token_desc(lone_op(held_op), ERR_NONE);
            start_token(c);
          end
        M_LINECOM:   if (c == CH_NL) mode = M_IDLE;
        M_BLOCK:     if (c == CH_STAR) mode = M_BLOCKSTAR;
        M_BLOCKSTAR:
          if (c == CH_SLASH) mode = M_IDLE;
          else if (c != CH_STAR) mode = M_BLOCK;
        default:     start_token(c);
      endcase
    end
    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fails_o++;
  endtask

  initial begin
    fails_o = 0;
    clear_scan();
  end

  always @(posedge clk_i) begin
    token_res_t w;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          report("unexpected result, type", token_type_o, -1);
        end else begin
          w = expected_tokens.pop_front();
          if (out_kind_o !== w.is_desc) report("out_kind", out_kind_o, w.is_desc);
          if (lexeme_byte_o !== w.lex) report("lexeme_byte", lexeme_byte_o, w.lex);
          if (token_type_o !== w.tok) report("token_type", token_type_o, w.tok);
          if (error_code_o !== w.err) report("error_code", error_code_o, w.err);
          if (start_line_o !== w.line) report("start_line", start_line_o, w.line);
          if (start_column_o !== w.col) report("start_column", start_column_o, w.col);
          if (lexeme_length_o !== w.len) report("lexeme_length", lexeme_length_o, w.len);
          if (last_o !== w.last) report("last", last_o, w.last);
        end
      end
      if (push && !full) tokenize_item(kind_i, char_code_i);
    end
  end

endmodule

// ===== tb/sv/tb_source_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer_unit
// Drives source text into the tokenizer: directed snippets for every token
// class, escape, comment and error case, then random well-formed token
// streams mixed with noise bytes under three idling patterns. The checker
// does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_unit;
  import stt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        kind_i = 1'b0;
  logic [7:0]  char_code_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_kind_o;
  logic [7:0]  lexeme_byte_o;
  logic [4:0]  token_type_o;
  logic [1:0]  error_code_o;
  logic [15:0] start_line_o, start_column_o, lexeme_length_o;
  logic        last_o;
  int          fails, pending;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          sent;

  always #2 clk_i = ~clk_i;

  source_text_tokenizer_unit u_top (.*);

  tb_source_text_tokenizer_checker u_chk (
    .clk_i, .rst_ni, .push, .full, .kind_i, .char_code_i, .empty, .pop,
    .out_kind_o, .lexeme_byte_o, .token_type_o, .error_code_o, .start_line_o,
    .start_column_o, .lexeme_length_o, .last_o,
    .fails_o(fails), .pending_o(pending)
  );

  always @(negedge clk_i) pop <= ($urandom_range(99) >= recv_idle);

  task automatic put_item(logic k, logic [7:0] c);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    kind_i <= k;
    char_code_i <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_item(1'b0, s[i]);
  endtask

  task automatic end_input();
    put_item(1'b1, 8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_token();
    string pool[] = '{"if", "else", "while", "return", "iff", "els", "whilex",
                      "returns", "_a1", "Zq", "==", "!=", "<=", ">=", "=", "!",
                      "<", ">", "/", "+", "-", "*", ";", "(", ")", "{", "}",
                      " ", "\n", "\t", "// note\n", "/* a**b */", "3.5", "42.1.7"};
    int n;
    case ($urandom_range(9))
      0: put_item(1'b0, 8'($urandom));
      1: begin
        put_item(1'b0, CH_QUOTE);
        n = $urandom_range(5);
        repeat (n) begin
          if ($urandom_range(3) == 0) begin
            put_item(1'b0, CH_BSL);
            put_item(1'b0, $urandom_range(1) ? 8'h6E : 8'($urandom_range(32, 126)));
          end else begin
            put_item(1'b0, 8'($urandom_range(32, 126)));
          end
        end
        if ($urandom_range(7) != 0) put_item(1'b0, CH_QUOTE);
      end
      2: begin
        n = $urandom_range(1, 6);
        repeat (n) put_item(1'b0, 8'($urandom_range(1) ? $urandom_range(97, 122)
                                                         : $urandom_range(48, 57)));
      end
      default: put_text(pool[$urandom_range(pool.size() - 1)]);
    endcase
    if ($urandom_range(2) == 0) put_item(1'b0, 8'h20);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed snippets
    put_text("if else while return iffy _x9 3.14.5");
    end_input();
    put_text("\"a\\n\\t\\\"\\\\\\q\\\n\" == != <= >= = ! < > / + - * ; ( ) { }");
    end_input();
    put_text("//c\n/* x ** */@");
    put_item(1'b0, 8'h00);
    put_item(1'b0, 8'hFF);
    put_item(1'b0, 8'h80);
    put_text("\"ab\n\"c\\");
    end_input();
    put_text("7 <");
    end_input();
    put_text("/* open");
    end_input();
    end_input();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 12 : (phase == 1) ? 84 : 0;
      recv_idle = (phase == 0) ? 84 : (phase == 1) ? 12 : 0;
      sent = 0;
      while (sent < 95) begin
        random_token();
        if ($urandom_range(29) == 0) end_input();
      end
      end_input();
    end

    drain();
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== source_text_tokenizer_unit.f =====
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_fifo.sv
rtl/stt_back.sv
rtl/source_text_tokenizer_unit.sv
tb/sv/tb_source_text_tokenizer_checker.sv
tb/sv/tb_source_text_tokenizer_unit.sv
